// File: rtl/pfba_pkg.sv
`timescale 1ns / 1ps
// Package for the page frame bitmap allocator: sizes, action and status codes,
// beat types. No dependencies.
package pfba_pkg;

    localparam int NUM_FRAMES = 32768;
    localparam int NGROUPS    = NUM_FRAMES / 8;
    localparam int GRP_W      = $clog2(NGROUPS);
    localparam int FRM_W      = GRP_W + 3;

    localparam logic [GRP_W-1:0] LAST_GRP    = GRP_W'(NGROUPS - 1);
    localparam logic [15:0]      LIMIT_FRAME = 16'((NGROUPS - 1) * 8);
    localparam logic [15:0]      LIMIT_RESET = 16'd256;
    localparam logic [15:0]      COUNT_MAX   = 16'hFFFF;
    localparam logic [7:0]       GROUP_FULL  = 8'hFF;

    typedef enum logic [2:0] {
        A_ONE   = 3'd0,
        A_RUN   = 3'd1,
        A_FREE  = 3'd2,
        A_MARK  = 3'd3,
        A_COUNT = 3'd4,
        A_CLAIM = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FAIL = 2'd1,
        ST_IGN  = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]  action;
        logic [14:0] frame_index;
        logic [15:0] frame_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [14:0] granted_frame;
        logic [15:0] used_frames;
        logic [15:0] free_frames;
    } rsp_t;

endpackage

// File: rtl/pfba_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pfba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Top level of the page frame bitmap allocator.
// Depends on pfba_pkg and pfba_ram.

// One item at a time. The bitmap sits in a RAM of 8-frame groups with one
// read port; each group visited is read, then checked or written back. A
// single-frame request skips full groups from the hint, then sets one bit; a
// run request also scans groups for a run and then writes each group of it;
// free reads one group and writes it back if the frame was used; region
// actions visit each group of the region, while counting only updates the
// counter. After reset a clearing pass sets every group to used; no request
// is taken until it ends, while configuration writes are taken at any time.
module page_frame_bitmap_allocator
    import pfba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  req_t        req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output rsp_t        rsp,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_HINT_RD, S_HINT_CHK, S_RUN_RD, S_RUN_CHK,
        S_FILL_RD, S_FILL_WR, S_FREE_CHK, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [GRP_W-1:0] hint_reg, hint_next;
    logic [GRP_W-1:0] grp_reg, grp_next;
    logic [15:0]      used_reg, used_next;
    logic [15:0]      free_reg, free_next;
    logic [15:0]      limit_reg, limit_next;
    logic [2:0]       act_reg, act_next;
    logic [15:0]      cnt_reg, cnt_next;
    logic [15:0]      run_reg, run_next;
    logic [14:0]      lo_reg, lo_next;
    logic [15:0]      hi_reg, hi_next;
    logic             fillv_reg, fillv_next;
    logic [1:0]       st_reg, st_next;
    logic [14:0]      gnt_reg, gnt_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             mem_we;
    logic [GRP_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata, mem_rdata;

    pfba_ram #(.WIDTH(8), .DEPTH(NGROUPS)) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    function automatic logic [15:0] cnt_add(input logic [15:0] c, input logic [15:0] n);
        logic [16:0] s;
        s = {1'b0, c} + {1'b0, n};
        return s[16] ? COUNT_MAX : s[15:0];
    endfunction

    function automatic logic [15:0] cnt_sub(input logic [15:0] c, input logic [15:0] n);
        return (n > c) ? 16'd0 : c - n;
    endfunction

    function automatic logic [2:0] first_clear(input logic [7:0] d);
        logic [2:0] idx;
        idx = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (!d[j])
            begin
                idx = 3'(j);
            end
        end
        return idx;
    endfunction

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        logic [15:0] run_v;
        logic        found_v;
        logic [15:0] start_v;
        logic [14:0] base_v;
        logic [7:0]  mask_v;
        logic [15:0] pos_v;
        logic [2:0]  bit_v;

        state_next     = state_reg;
        hint_next      = hint_reg;
        grp_next       = grp_reg;
        used_next      = used_reg;
        free_next      = free_reg;
        limit_next     = cfg_we ? cfg_wdata : limit_reg;
        act_next       = act_reg;
        cnt_next       = cnt_reg;
        run_next       = run_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        fillv_next     = fillv_reg;
        st_next        = st_reg;
        gnt_next       = gnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        mem_we    = 1'b0;
        mem_waddr = grp_reg;
        mem_wdata = GROUP_FULL;
        mem_raddr = grp_reg;

        run_v   = run_reg;
        found_v = 1'b0;
        start_v = 16'd0;
        base_v  = {hint_reg, 3'b000};
        mask_v  = 8'd0;
        pos_v   = 16'd0;
        bit_v   = first_clear(mem_rdata);

        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = GROUP_FULL;
                grp_next  = grp_reg + 1'b1;
                if (grp_reg == LAST_GRP)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    act_next = req.action;
                    cnt_next = req.frame_count;
                    lo_next  = req.frame_index;
                    st_next  = ST_IGN;
                    gnt_next = 15'd0;
                    case (req.action)
                        A_ONE:
                        begin
                            state_next = S_HINT_RD;
                        end
                        A_RUN:
                        begin
                            state_next = (req.frame_count == 16'd0) ? S_DONE : S_HINT_RD;
                        end
                        A_FREE:
                        begin
                            mem_raddr  = req.frame_index[14:3];
                            state_next = S_FREE_CHK;
                        end
                        A_MARK, A_COUNT, A_CLAIM:
                        begin
                            state_next = S_DONE;
                            if ({1'b0, req.frame_index} >= limit_reg)
                            begin
                                st_next = ST_OK;
                                if (req.action == A_MARK)
                                begin
                                    free_next = cnt_add(free_reg, req.frame_count);
                                end
                                else if (req.action == A_COUNT)
                                begin
                                    used_next = cnt_add(used_reg, req.frame_count);
                                end
                                else
                                begin
                                    free_next = cnt_sub(free_reg, req.frame_count);
                                    used_next = cnt_add(used_reg, req.frame_count);
                                end
                                if (req.action != A_COUNT && req.frame_count != 16'd0)
                                begin
                                    hi_next = ({1'b0, req.frame_index} + {1'b0, req.frame_count}
                                               > 17'(NUM_FRAMES))
                                              ? 16'(NUM_FRAMES)
                                              : req.frame_count + {1'b0, req.frame_index};
                                    fillv_next = (req.action == A_CLAIM);
                                    grp_next   = req.frame_index[14:3];
                                    state_next = S_FILL_RD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_HINT_RD:
            begin
                mem_raddr = hint_reg;
                if (hint_reg == LAST_GRP)
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_HINT_CHK;
                end
            end
            S_HINT_CHK:
            begin
                if (mem_rdata == GROUP_FULL)
                begin
                    hint_next  = hint_reg + 1'b1;
                    state_next = S_HINT_RD;
                end
                else if (act_reg == A_ONE)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = hint_reg;
                    mem_wdata  = mem_rdata | (8'd1 << bit_v);
                    used_next  = cnt_add(used_reg, 16'd1);
                    free_next  = cnt_sub(free_reg, 16'd1);
                    gnt_next   = {hint_reg, bit_v};
                    st_next    = ST_OK;
                    state_next = S_DONE;
                end
                else if (cnt_reg > LIMIT_FRAME || {1'b0, base_v} > LIMIT_FRAME - cnt_reg)
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    grp_next   = hint_reg;
                    run_next   = 16'd0;
                    state_next = S_RUN_RD;
                end
            end
            S_RUN_RD:
            begin
                if (grp_reg == LAST_GRP)
                begin
                    st_next    = ST_FAIL;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_RUN_CHK;
                end
            end
            S_RUN_CHK:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    if (!found_v)
                    begin
                        run_v = mem_rdata[j] ? 16'd0 : run_v + 16'd1;
                        if (run_v == cnt_reg)
                        begin
                            found_v = 1'b1;
                            start_v = {1'b0, grp_reg, 3'(j)} + 16'd1 - cnt_reg;
                        end
                    end
                end
                if (found_v)
                begin
                    lo_next    = start_v[14:0];
                    hi_next    = start_v + cnt_reg;
                    fillv_next = 1'b1;
                    grp_next   = start_v[14:3];
                    state_next = S_FILL_RD;
                end
                else
                begin
                    run_next   = run_v;
                    grp_next   = grp_reg + 1'b1;
                    state_next = S_RUN_RD;
                end
            end
            S_FILL_RD:
            begin
                state_next = S_FILL_WR;
            end
            S_FILL_WR:
            begin
                for (int j = 0; j < 8; j++)
                begin
                    pos_v     = {1'b0, grp_reg, 3'(j)};
                    mask_v[j] = (pos_v >= {1'b0, lo_reg}) && (pos_v < hi_reg);
                end
                mem_we    = 1'b1;
                mem_wdata = fillv_reg ? (mem_rdata | mask_v) : (mem_rdata & ~mask_v);
                if ({1'b0, grp_reg, 3'b000} + 16'd8 >= hi_reg)
                begin
                    if (act_reg == A_RUN)
                    begin
                        used_next = cnt_add(used_reg, cnt_reg);
                        free_next = cnt_sub(free_reg, cnt_reg);
                        gnt_next  = lo_reg;
                        st_next   = ST_OK;
                    end
                    state_next = S_DONE;
                end
                else
                begin
                    grp_next   = grp_reg + 1'b1;
                    state_next = S_FILL_RD;
                end
            end
            S_FREE_CHK:
            begin
                if (mem_rdata[lo_reg[2:0]])
                begin
                    mem_we    = 1'b1;
                    mem_waddr = lo_reg[14:3];
                    mem_wdata = mem_rdata & ~(8'd1 << lo_reg[2:0]);
                    used_next = cnt_sub(used_reg, 16'd1);
                    free_next = cnt_add(free_reg, 16'd1);
                    if (hint_reg > lo_reg[14:3])
                    begin
                        hint_next = lo_reg[14:3];
                    end
                    st_next = ST_OK;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.status        = st_reg;
                    rsp_next.granted_frame = gnt_reg;
                    rsp_next.used_frames   = used_reg;
                    rsp_next.free_frames   = free_reg;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            hint_reg      <= '0;
            grp_reg       <= '0;
            used_reg      <= '0;
            free_reg      <= '0;
            limit_reg     <= LIMIT_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            grp_reg       <= grp_next;
            used_reg      <= used_next;
            free_reg      <= free_next;
            limit_reg     <= limit_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        cnt_reg   <= cnt_next;
        run_reg   <= run_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        fillv_reg <= fillv_next;
        st_reg    <= st_next;
        gnt_reg   <= gnt_next;
        rsp_reg   <= rsp_next;
    end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Testbench for page_frame_bitmap_allocator: random and directed actions,
// checked against a behavioral bitmap allocator kept in a scoreboard class.
// Depends on pfba_pkg and the allocator RTL.
module testbench;
    import pfba_pkg::*;

    class frame_scoreboard;
        bit          used_bits [NUM_FRAMES];
        int unsigned hint;
        int unsigned used_cnt;
        int unsigned free_cnt;
        int unsigned res_limit;
        rsp_t        pending [$];
        int          errors;

        function void clear();
            foreach (used_bits[i]) used_bits[i] = 1'b1;
            hint = 0;
            used_cnt = 0;
            free_cnt = 0;
            res_limit = 256;
            errors = 0;
        endfunction

        function bit used_at(int unsigned f);
            if (f >= NUM_FRAMES) return 1'b1;
            return used_bits[f];
        endfunction

        function void put_bit(int unsigned f, bit v);
            if (f < NUM_FRAMES) used_bits[f] = v;
        endfunction

        function int unsigned sat_add(int unsigned c, int unsigned n);
            return (c + n > 65535) ? 65535 : c + n;
        endfunction

        function int unsigned sat_sub(int unsigned c, int unsigned n);
            return (n > c) ? 0 : c - n;
        endfunction

        function bit group_full(int unsigned g);
            for (int i = 0; i < 8; i++)
                if (!used_bits[g*8+i]) return 1'b0;
            return 1'b1;
        endfunction

        function bit skip_full_groups();
            while (hint < NGROUPS - 1 && group_full(hint)) hint++;
            return hint < NGROUPS - 1;
        endfunction

        function void note_request(req_t r);
            rsp_t        e;
            int unsigned f, lim, s, busy, n;
            bit          ok;
            e.status = ST_IGN;
            e.granted_frame = '0;
            n = r.frame_count;
            case (r.action)
                A_ONE:
                begin
                    if (!skip_full_groups())
                        e.status = ST_FAIL;
                    else
                    begin
                        f = hint * 8;
                        while (used_at(f)) f++;
                        put_bit(f, 1'b1);
                        used_cnt = sat_add(used_cnt, 1);
                        free_cnt = sat_sub(free_cnt, 1);
                        e.granted_frame = f[14:0];
                        e.status = ST_OK;
                    end
                end
                A_RUN:
                begin
                    if (n != 0)
                    begin
                        lim = (NGROUPS - 1) * 8;
                        e.status = ST_FAIL;
                        if (skip_full_groups() && n <= lim && hint * 8 <= lim - n)
                        begin
                            s = hint * 8;
                            busy = 0;
                            ok = 1'b1;
                            for (int i = 0; i < n; i++)
                                if (used_at(s + i)) busy++;
                            while (busy > 0)
                            begin
                                if (s + n >= lim)
                                begin
                                    ok = 1'b0;
                                    break;
                                end
                                if (used_at(s)) busy--;
                                if (used_at(s + n)) busy++;
                                s++;
                            end
                            if (ok)
                            begin
                                for (int i = 0; i < n; i++) put_bit(s + i, 1'b1);
                                used_cnt = sat_add(used_cnt, n);
                                free_cnt = sat_sub(free_cnt, n);
                                e.granted_frame = s[14:0];
                                e.status = ST_OK;
                            end
                        end
                    end
                end
                A_FREE:
                begin
                    f = r.frame_index;
                    if (used_at(f))
                    begin
                        put_bit(f, 1'b0);
                        used_cnt = sat_sub(used_cnt, 1);
                        free_cnt = sat_add(free_cnt, 1);
                        if (hint > f / 8) hint = f / 8;
                        e.status = ST_OK;
                    end
                end
                A_MARK, A_COUNT, A_CLAIM:
                begin
                    if (r.frame_index >= res_limit)
                    begin
                        f = r.frame_index;
                        if (r.action == A_MARK)
                        begin
                            free_cnt = sat_add(free_cnt, n);
                            for (int unsigned i = f; i < f + n && i < NUM_FRAMES; i++)
                                used_bits[i] = 1'b0;
                        end
                        else if (r.action == A_COUNT)
                            used_cnt = sat_add(used_cnt, n);
                        else
                        begin
                            for (int unsigned i = f; i < f + n && i < NUM_FRAMES; i++)
                                used_bits[i] = 1'b1;
                            free_cnt = sat_sub(free_cnt, n);
                            used_cnt = sat_add(used_cnt, n);
                        end
                        e.status = ST_OK;
                    end
                end
                default: ;
            endcase
            e.used_frames = used_cnt[15:0];
            e.free_frames = free_cnt[15:0];
            pending.push_back(e);
        endfunction

        function void check_response(rsp_t a);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected response beat");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.status !== e.status)
            begin
                $error("status exp %0d got %0d", e.status, a.status);
                errors++;
            end
            if (a.granted_frame !== e.granted_frame)
            begin
                $error("granted_frame exp %0d got %0d", e.granted_frame, a.granted_frame);
                errors++;
            end
            if (a.used_frames !== e.used_frames)
            begin
                $error("used_frames exp %0d got %0d", e.used_frames, a.used_frames);
                errors++;
            end
            if (a.free_frames !== e.free_frames)
            begin
                $error("free_frames exp %0d got %0d", e.free_frames, a.free_frames);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    frame_scoreboard sb;
    bit          calm;
    int unsigned cycles;

    page_frame_bitmap_allocator uut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 80000000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && rsp_valid && rsp_ready) sb.check_response(rsp);

    // receiver stalls in bursts
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 8);
                rsp_ready <= 1'b0;
                repeat (n) @(negedge clk);
            end
            rsp_ready <= 1'b1;
        end
    end

    task automatic send_beat(logic [2:0] act, logic [14:0] idx, logic [15:0] cnt);
        int n;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            n = $urandom_range(1, 8);
            req_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= '{action: act, frame_index: idx, frame_count: cnt};
        do @(posedge clk); while (!req_ready);
        sb.note_request(req);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_limit(logic [15:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.res_limit = v;
    endtask

    task automatic random_beat();
        int unsigned k;
        logic [14:0] idx;
        logic [15:0] cnt;
        k = $urandom_range(0, 99);
        idx = 15'($urandom);
        cnt = 16'($urandom_range(0, 40));
        if (k < 30) send_beat(A_ONE, idx, cnt);
        else if (k < 45) send_beat(A_RUN, idx, 16'($urandom_range(0, 24)));
        else if (k < 70) send_beat(A_FREE, 15'($urandom_range(0, 1023)), cnt);
        else if (k < 80) send_beat(A_MARK, 15'($urandom_range(0, 1100)), cnt);
        else if (k < 85) send_beat(A_COUNT, idx, 16'($urandom));
        else if (k < 93) send_beat(A_CLAIM, 15'($urandom_range(0, 1100)), cnt);
        else if (k < 96) send_beat(A_FREE, idx, 16'($urandom));
        else send_beat(3'($urandom_range(6, 7)), idx, 16'($urandom));
    endtask

    initial
    begin
        sb = new();
        sb.clear();
        calm = 1'b0;
        cycles = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        // directed: fully used bitmap, then regions and edge cases
        send_beat(A_ONE, 0, 0);
        send_beat(A_RUN, 0, 1);
        send_beat(A_RUN, 0, 0);
        send_beat(A_FREE, 15'h7FFF, 0);
        send_beat(A_FREE, 15'h7FFF, 0);
        send_beat(A_MARK, 100, 50);
        send_beat(A_MARK, 256, 512);
        send_beat(A_ONE, 0, 0);
        send_beat(A_RUN, 0, 16'd32768);
        send_beat(A_RUN, 0, 16'hFFFF);
        send_beat(A_RUN, 0, 40);
        send_beat(A_CLAIM, 300, 4);
        send_beat(A_COUNT, 1000, 16'hFFFF);
        send_beat(A_COUNT, 1000, 16'hFFFF);
        send_beat(A_MARK, 15'h7FF0, 16'hFFFF);
        send_beat(A_ONE, 0, 0);
        send_beat(A_CLAIM, 15'h7FF0, 16'hFFFF);
        send_beat(A_CLAIM, 256, 16'hFFFF);
        send_beat(A_ONE, 0, 0);
        send_beat(A_RUN, 0, 3);
        send_beat(3'd6, 0, 0);
        send_beat(3'd7, 15'h7FFF, 16'hFFFF);
        write_limit(16'd0);
        send_beat(A_MARK, 0, 600);
        write_limit(16'hFFFF);
        send_beat(A_MARK, 15'h7FFF, 1);
        write_limit(16'd32768);
        send_beat(A_CLAIM, 15'h7FFF, 1);
        write_limit(16'd256);
        for (int i = 0; i < 950; i++)
        begin
            if (i == 300) drain();
            if (i == 400) write_limit(16'd0);
            if (i == 600) write_limit(16'($urandom_range(0, 1200)));
            if (i == 800) calm = 1'b1;
            random_beat();
        end
        drain();
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// File: page_frame_bitmap_allocator.f
rtl/pfba_pkg.sv
rtl/pfba_ram.sv
rtl/page_frame_bitmap_allocator.sv
verif/testbench.sv
